>>> src/axis_to_motor_mixer_core_assert.svh
// Assertion macros shared by the mixer modules.
`ifndef AXIS_TO_MOTOR_MIXER_CORE_ASSERT_SVH
`define AXIS_TO_MOTOR_MIXER_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define AMM_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define AMM_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

>>> src/amm_pkg.sv
package amm_pkg;

	localparam int TableEntriesDef = 32;
	localparam int MotorCountDef   = 8;
	localparam int AxisCountDef    = 6;
	localparam int OneQ15          = 32768;

	typedef enum logic [1:0] {
		FUNC_MIX    = 2'd0,
		FUNC_ADD    = 2'd1,
		FUNC_REMOVE = 2'd2,
		FUNC_CLEAR  = 2'd3
	} func_t;

	localparam logic CFG_DEAD_BAND = 1'b0;
	localparam logic CFG_EXPO_MIX  = 1'b1;

	typedef struct packed {
		logic [1:0]         func;
		logic [31:0]        axes_01;
		logic [31:0]        axes_23;
		logic [31:0]        axes_45;
		logic [3:0]         map_motor;
		logic [1:0]         map_kind;
		logic [2:0]         map_axis;
		logic signed [15:0] map_scale;
		logic               map_inverted;
		logic               map_enabled;
		logic [4:0]         entry_index;
	} in_beat_t;

	typedef struct packed {
		logic [15:0] motor_out_0;
		logic [15:0] motor_out_1;
		logic [15:0] motor_out_2;
		logic [15:0] motor_out_3;
		logic [15:0] motor_out_4;
		logic [15:0] motor_out_5;
		logic [15:0] motor_out_6;
		logic [15:0] motor_out_7;
		logic        status;
		logic [5:0]  entries_in_use;
	} out_beat_t;

	// Stored table entry, 27 bits.
	typedef struct packed {
		logic [3:0]         motor;
		logic [1:0]         kind;
		logic [2:0]         axis;
		logic signed [15:0] scale;
		logic               inverted;
		logic               enabled;
	} entry_t;

	localparam int EntryW = $bits(entry_t);

	// Controller to datapath commands.
	typedef struct packed {
		logic clear_sums;
		logic shape_start;
		logic accumulate;
		logic finish_mix;
	} dp_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic shape_done;
	} dp_sts_t;

endpackage

>>> src/axis_to_motor_mixer_core.sv
// Stick-to-motor mixer with a mapping table of up to TableEntries entries.
// Input channel in_valid/in_stall carries one in_beat_t beat: a mix frame
// (func 0) or a table operation (add, remove by index, clear one motor).
// Output channel out_valid/out_stall returns one out_beat_t beat per input
// beat, with eight motor drives, a status bit and the entry count.
// Configuration channel cfg_valid/cfg_ready writes dead_band (index 0) and
// expo_mix (index 1); it is always ready. The user must see that it is
// used only while idle; the block itself does not enforce this. One
// beat is handled at a time: in_stall is high from acceptance until
// the result beat is taken. A mix frame shapes each enabled entry
// through the 32-step serial divider of the deadzone rescale plus the
// expo multiplies and skips each disabled entry. Add writes one entry,
// remove and clear walk the table entry by entry through the table RAM,
// and a rejected operation goes straight to its result.
// Reset clears the entry count and loads dead_band 3277 and expo_mix 0;
// table contents stay as they were and are read only below the count.
// While out_stall is high the result beat stays valid and unchanged, and
// no new input beat is taken.
module axis_to_motor_mixer_core import amm_pkg::*; #(
	parameter int TableEntries = TableEntriesDef,
	parameter int MotorCount   = MotorCountDef,
	parameter int AxisCount    = AxisCountDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_beat_t    in_beat,
	output logic        out_valid,
	input  logic        out_stall,
	output out_beat_t   out_beat,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int IdxW = $clog2(TableEntries);

	logic [14:0] dead_band_q;
	logic [15:0] expo_mix_q;

	dp_cmd_t      cmd;
	dp_sts_t      sts;
	logic         ram_we;
	logic [IdxW-1:0] ram_waddr;
	logic [IdxW-1:0] ram_raddr;
	entry_t       ram_wdata;
	entry_t       ram_rdata;
	logic [95:0]  axes_q;
	logic         status;
	logic         is_mix;
	logic [5:0]   count;
	logic [15:0]  mo [8];

	assign cfg_ready = 1'b1;

	// Registers; expo_mix saturates at 1.0.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_band_q <= 15'd3277;
			expo_mix_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_DEAD_BAND) dead_band_q <= cfg_data[14:0];
			else expo_mix_q <= (cfg_data > 16'(OneQ15)) ? 16'(OneQ15) : cfg_data;
		end
	end

	amm_ram #(.Width(EntryW), .Depth(TableEntries)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	amm_ctrl #(.TableEntries(TableEntries)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_beat    (in_beat),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_status (status),
		.out_is_mix (is_mix),
		.count_out  (count),
		.cmd        (cmd),
		.sts        (sts),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.axes_q     (axes_q)
	);

	amm_datapath #(.MotorCount(MotorCount), .AxisCount(AxisCount)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.entry     (ram_rdata),
		.axes      (axes_q),
		.dead_band (dead_band_q),
		.expo_mix  (expo_mix_q),
		.motor_out (mo)
	);

	// Table operations report zero drive on every motor.
	always_comb begin
		out_beat.motor_out_0    = is_mix ? mo[0] : '0;
		out_beat.motor_out_1    = is_mix ? mo[1] : '0;
		out_beat.motor_out_2    = is_mix ? mo[2] : '0;
		out_beat.motor_out_3    = is_mix ? mo[3] : '0;
		out_beat.motor_out_4    = is_mix ? mo[4] : '0;
		out_beat.motor_out_5    = is_mix ? mo[5] : '0;
		out_beat.motor_out_6    = is_mix ? mo[6] : '0;
		out_beat.motor_out_7    = is_mix ? mo[7] : '0;
		out_beat.status         = status;
		out_beat.entries_in_use = count;
	end

`include "axis_to_motor_mixer_core_assert.svh"

	`AMM_ASSERT_IMP(a_expo_range, clk, arst_n, 1'b1, expo_mix_q <= 16'(OneQ15))
	`AMM_ASSERT_IMP(a_no_accept_busy, clk, arst_n, out_valid, in_stall)
	`AMM_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(out_beat))

endmodule

>>> src/amm_ram.sv
module amm_ram #(
	parameter int Width = 8,
	parameter int Depth = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> src/amm_datapath.sv
module amm_datapath import amm_pkg::*; #(
	parameter int MotorCount = MotorCountDef,
	parameter int AxisCount  = AxisCountDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	input  entry_t      entry,
	input  logic [95:0] axes,
	input  logic [14:0] dead_band,
	input  logic [15:0] expo_mix,
	output logic [15:0] motor_out [8]
);

	// Phases of the shaping of one entry.
	typedef enum logic [5:0] {
		SH_IDLE = 6'b000001,
		SH_DIV  = 6'b000010,
		SH_SQ   = 6'b000100,
		SH_F    = 6'b001000,
		SH_Y    = 6'b010000,
		SH_TERM = 6'b100000
	} sh_state_t;

	sh_state_t           sh_q;
	logic [4:0]          div_cnt_q;
	logic [32:0]         rem_q;
	logic [16:0]         quo_q;
	logic [31:0]         num_q;
	logic                neg_q;
	logic signed [17:0]  x_q;
	logic [31:0]         sq_q;
	logic signed [18:0]  f_q;
	logic signed [18:0]  y_q;
	logic signed [47:0]  term_q;
	logic signed [47:0]  sum_q [8];
	logic                inv_q;
	logic signed [15:0]  scale_q;
	logic [3:0]          motor_q;

	logic signed [15:0] ax_val;
	logic signed [17:0] dz_mag;
	logic               dz_zero;
	logic [15:0]        span;
	logic [32:0]        rem_sh;
	logic [33:0]        qq;
	logic signed [48:0] ef;
	logic signed [36:0] xf;
	logic signed [18:0] yy;
	logic signed [35:0] ys;
	logic signed [35:0] yq;

	always_comb begin
		ax_val = '0;
		if ((entry.kind == 2'd0 || entry.kind == 2'd1) && (32'(entry.axis) < AxisCount)) begin
			ax_val = axes[16*entry.axis +: 16];
		end
		dz_zero = (($signed(18'(ax_val)) > -$signed({3'b0, dead_band}))
			&& ($signed(18'(ax_val)) < $signed({3'b0, dead_band})))
			|| ($signed(18'(ax_val)) == $signed({3'b0, dead_band}));
		if (ax_val > $signed({1'b0, dead_band})) begin
			dz_mag = 18'(ax_val) - $signed({3'b0, dead_band});
		end else begin
			dz_mag = -(18'(ax_val) + $signed({3'b0, dead_band}));
		end
		span   = 16'(OneQ15) - {1'b0, dead_band};
		rem_sh = {rem_q[31:0], num_q[31]};
		qq     = quo_q * quo_q;
		ef     = $signed({1'b0, expo_mix}) * $signed({1'b0, sq_q});
		xf     = x_q * f_q;
		yy     = inv_q ? -y_q : y_q;
		ys     = 36'(yy) * scale_q;
		yq     = ys / 36'sd4096;
	end

	assign sts.shape_done = (sh_q == SH_TERM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_q <= SH_IDLE;
		end else begin
			unique case (sh_q)
				SH_IDLE: if (cmd.shape_start) sh_q <= SH_DIV;
				SH_DIV:  if (div_cnt_q == 5'd0) sh_q <= SH_SQ;
				SH_SQ:   sh_q <= SH_F;
				SH_F:    sh_q <= SH_Y;
				SH_Y:    sh_q <= SH_TERM;
				SH_TERM: sh_q <= SH_IDLE;
				default: sh_q <= SH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shape_start) begin
			num_q     <= dz_zero ? '0 : {dz_mag[16:0], 15'd0};
			neg_q     <= !dz_zero && !(ax_val > $signed({1'b0, dead_band}));
			rem_q     <= '0;
			quo_q     <= '0;
			div_cnt_q <= 5'd31;
			inv_q     <= entry.inverted;
			scale_q   <= entry.scale;
			motor_q   <= entry.motor;
		end else if (sh_q == SH_DIV) begin
			// Restoring divide, one quotient bit per cycle.
			num_q <= {num_q[30:0], 1'b0};
			if (rem_sh >= {17'd0, span}) begin
				rem_q <= rem_sh - {17'd0, span};
				quo_q <= {quo_q[15:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[15:0], 1'b0};
			end
			div_cnt_q <= div_cnt_q - 5'd1;
		end
		// The square only needs the magnitude, so it starts from the quotient.
		if (sh_q == SH_SQ) begin
			x_q  <= neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
			sq_q <= 32'(qq >> 15);
		end
		if (sh_q == SH_F) begin
			if (expo_mix == '0) begin
				f_q <= '0;
			end else begin
				f_q <= 19'(ef >>> 15) + 19'($signed({3'b0, 16'(OneQ15) - expo_mix}));
			end
		end
		if (sh_q == SH_Y) begin
			if (expo_mix == '0) begin
				y_q <= 19'(x_q);
			end else begin
				y_q <= 19'(xf / 37'sd32768);
			end
		end
		if (cmd.accumulate) begin
			term_q <= 48'(yq);
		end
	end

	// The term is registered in SH_TERM and added on the finish pulse.
	always_ff @(posedge clk) begin
		if (cmd.clear_sums) begin
			for (int m = 0; m < 8; m++) sum_q[m] <= '0;
		end else if (cmd.finish_mix && (32'(motor_q) < MotorCount)) begin
			sum_q[motor_q[2:0]] <= sum_q[motor_q[2:0]] + term_q;
		end
	end

	always_comb begin
		logic signed [48:0] o;
		for (int m = 0; m < 8; m++) begin
			o = 49'sd16384 + 49'(sum_q[m] / 48'sd2);
			if (o < 0) motor_out[m] = '0;
			else if (o > 49'sd32768) motor_out[m] = 16'd32768;
			else motor_out[m] = o[15:0];
		end
	end

endmodule

>>> src/amm_ctrl.sv
module amm_ctrl import amm_pkg::*; #(
	parameter int TableEntries = TableEntriesDef
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  in_beat_t                       in_beat,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           out_status,
	output logic                           out_is_mix,
	output logic [5:0]                     count_out,
	output dp_cmd_t                        cmd,
	input  dp_sts_t                        sts,
	output logic                           ram_we,
	output logic [$clog2(TableEntries)-1:0] ram_waddr,
	output entry_t                         ram_wdata,
	output logic [$clog2(TableEntries)-1:0] ram_raddr,
	input  entry_t                         ram_rdata,
	output logic [95:0]                    axes_q
);

	localparam int IdxW = $clog2(TableEntries);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_READ  = 8'b00000010,
		ST_SHAPE = 8'b00000100,
		ST_ACC   = 8'b00001000,
		ST_ADD   = 8'b00010000,
		ST_MOVE  = 8'b00100000,
		ST_WRITE = 8'b01000000,
		ST_OUT   = 8'b10000000
	} st_t;

	st_t         st_q;
	logic [5:0]  cnt_q;
	logic [5:0]  rd_q;
	logic [5:0]  wr_q;
	logic [1:0]  func_q;
	logic [3:0]  motor_q;
	logic        status_q;
	logic        wait_q;
	entry_t      add_q;

	assign in_stall   = (st_q != ST_IDLE);
	assign out_valid  = (st_q == ST_OUT);
	assign out_status = status_q;
	assign out_is_mix = (func_q == FUNC_MIX);
	assign count_out  = cnt_q;
	assign ram_raddr  = rd_q[IdxW-1:0];
	assign ram_waddr  = wr_q[IdxW-1:0];

	always_comb begin
		cmd = '0;
		cmd.clear_sums  = (st_q == ST_IDLE) && in_valid;
		cmd.shape_start = (st_q == ST_SHAPE) && !wait_q && ram_rdata.enabled;
		cmd.accumulate  = sts.shape_done;
		cmd.finish_mix  = (st_q == ST_ACC);
		ram_we    = 1'b0;
		ram_wdata = ram_rdata;
		if (st_q == ST_ADD) begin
			ram_we    = 1'b1;
			ram_wdata = add_q;
		end else if (st_q == ST_WRITE) begin
			ram_we = (func_q == FUNC_REMOVE) || (ram_rdata.motor != motor_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			cnt_q    <= '0;
			rd_q     <= '0;
			wr_q     <= '0;
			func_q   <= FUNC_MIX;
			motor_q  <= '0;
			status_q <= 1'b0;
			wait_q   <= 1'b0;
			axes_q   <= '0;
			add_q    <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: if (in_valid) begin
					func_q   <= in_beat.func;
					motor_q  <= in_beat.map_motor;
					status_q <= 1'b0;
					axes_q   <= {in_beat.axes_45, in_beat.axes_23, in_beat.axes_01};
					add_q    <= {in_beat.map_motor, in_beat.map_kind, in_beat.map_axis,
						in_beat.map_scale, in_beat.map_inverted, in_beat.map_enabled};
					rd_q     <= '0;
					wr_q     <= '0;
					unique case (func_t'(in_beat.func))
						FUNC_MIX:    st_q <= (cnt_q == '0) ? ST_OUT : ST_READ;
						FUNC_ADD: begin
							if (32'(cnt_q) < TableEntries) begin
								wr_q <= cnt_q;
								st_q <= ST_ADD;
							end else begin
								status_q <= 1'b1;
								st_q     <= ST_OUT;
							end
						end
						FUNC_REMOVE: begin
							if ({1'b0, in_beat.entry_index} < cnt_q) begin
								rd_q <= {1'b0, in_beat.entry_index} + 6'd1;
								wr_q <= {1'b0, in_beat.entry_index};
								st_q <= ({1'b0, in_beat.entry_index} + 6'd1 < cnt_q)
									? ST_MOVE : ST_OUT;
								cnt_q <= cnt_q - 6'd1;
							end else begin
								status_q <= 1'b1;
								st_q     <= ST_OUT;
							end
						end
						FUNC_CLEAR: st_q <= (cnt_q == '0) ? ST_OUT : ST_MOVE;
						default:    st_q <= ST_OUT;
					endcase
				end
				ST_READ: begin
					st_q   <= ST_SHAPE;
					wait_q <= 1'b0;
				end
				ST_SHAPE: begin
					if (!wait_q) begin
						if (ram_rdata.enabled) wait_q <= 1'b1;
						else begin
							rd_q <= rd_q + 6'd1;
							st_q <= (rd_q + 6'd1 < cnt_q) ? ST_READ : ST_OUT;
						end
					end else if (sts.shape_done) begin
						st_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					rd_q <= rd_q + 6'd1;
					st_q <= (rd_q + 6'd1 < cnt_q) ? ST_READ : ST_OUT;
				end
				ST_ADD: begin
					cnt_q <= cnt_q + 6'd1;
					st_q  <= ST_OUT;
				end
				ST_MOVE: st_q <= ST_WRITE;
				ST_WRITE: begin
					if (ram_we) wr_q <= wr_q + 6'd1;
					rd_q <= rd_q + 6'd1;
					if (func_q == FUNC_REMOVE) begin
						st_q <= (rd_q + 6'd1 <= cnt_q) ? ST_MOVE : ST_OUT;
					end else if (rd_q + 6'd1 < cnt_q) begin
						st_q <= ST_MOVE;
					end else begin
						cnt_q <= wr_q + (ram_we ? 6'd1 : 6'd0);
						st_q  <= ST_OUT;
					end
				end
				ST_OUT: if (!out_stall) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

`include "axis_to_motor_mixer_core_assert.svh"

	`AMM_ASSERT_IMP(a_count_max, clk, arst_n, 1'b1, 32'(cnt_q) <= TableEntries)
	`AMM_ASSERT_IMP(a_busy_stall, clk, arst_n, st_q != ST_IDLE, in_stall)
	`AMM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)

endmodule

>>> tb/tb_axis_to_motor_mixer_core.sv
module tb_axis_to_motor_mixer_core;
	import amm_pkg::*;

	// Clock, reset and the three channels of the mixer.
	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_beat_t in_beat;
	logic out_valid;
	logic out_stall;
	out_beat_t out_beat;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [15:0] cfg_data;

	axis_to_motor_mixer_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_beat(in_beat),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_beat(out_beat),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// The predictor keeps its own copy of the mapping table, the entry count
	// and both registers. The table and count follow each accepted input beat.
	entry_t mix_table[TableEntriesDef];
	int unsigned table_count;
	int unsigned band_q15;
	int unsigned expo_q15;

	// Result beats still owed by the block, oldest first.
	out_beat_t owed_results[$];
	int error_count;
	int accepted_count;

	// Rescaling deadzone. A value exactly at +band is inside the band.
	function automatic longint shape_deadzone(longint x, longint band);
		longint span;
		span = OneQ15 - band;
		if ((x > -band && x < band) || x == band)
			return 0;
		if (x > band)
			return ((x - band) * OneQ15) / span;
		return ((x + band) * OneQ15) / span;
	endfunction

	// Cubic-ish expo blend: y = x * (e*x^2 + (1-e)). SystemVerilog division
	// truncates toward zero just as the block does; the square uses an
	// arithmetic shift.
	function automatic longint shape_expo(longint x, longint e);
		longint sq;
		longint f;
		if (e == 0)
			return x;
		sq = (x * x) >>> 15;
		f = (e * sq) / OneQ15 + (OneQ15 - e);
		return (x * f) / OneQ15;
	endfunction

	// Works out the result beat of one input beat and advances the table.
	function automatic out_beat_t predict_motor_drive(in_beat_t b);
		out_beat_t r;
		longint sums[8];
		longint axis_val[6];
		longint x;
		longint o;
		logic [15:0] drive[8];
		int unsigned keep;
		r = '0;
		for (int m = 0; m < 8; m++) begin
			sums[m] = 0;
			drive[m] = '0;
		end
		case (func_t'(b.func))
			FUNC_MIX: begin
				axis_val[0] = longint'(signed'(b.axes_01[15:0]));
				axis_val[1] = longint'(signed'(b.axes_01[31:16]));
				axis_val[2] = longint'(signed'(b.axes_23[15:0]));
				axis_val[3] = longint'(signed'(b.axes_23[31:16]));
				axis_val[4] = longint'(signed'(b.axes_45[15:0]));
				axis_val[5] = longint'(signed'(b.axes_45[31:16]));
				for (int i = 0; i < table_count; i++) begin
					if (mix_table[i].enabled && mix_table[i].motor < MotorCountDef) begin
						x = 0;
						if (mix_table[i].kind <= 2'd1 && mix_table[i].axis < AxisCountDef)
							x = axis_val[mix_table[i].axis];
						x = shape_deadzone(x, band_q15);
						x = shape_expo(x, expo_q15);
						if (mix_table[i].inverted)
							x = -x;
						sums[mix_table[i].motor] += (x * longint'(mix_table[i].scale)) / 4096;
					end
				end
				for (int m = 0; m < 8; m++) begin
					o = 16384 + sums[m] / 2;
					if (o < 0)
						o = 0;
					if (o > OneQ15)
						o = OneQ15;
					drive[m] = o[15:0];
				end
			end
			FUNC_ADD: begin
				if (table_count < TableEntriesDef) begin
					mix_table[table_count] = {b.map_motor, b.map_kind, b.map_axis,
						b.map_scale, b.map_inverted, b.map_enabled};
					table_count++;
				end else begin
					r.status = 1'b1;
				end
			end
			FUNC_REMOVE: begin
				if (b.entry_index < table_count) begin
					for (int i = b.entry_index; i + 1 < table_count; i++)
						mix_table[i] = mix_table[i + 1];
					table_count--;
				end else begin
					r.status = 1'b1;
				end
			end
			default: begin
				keep = 0;
				for (int i = 0; i < table_count; i++) begin
					if (mix_table[i].motor != b.map_motor) begin
						mix_table[keep] = mix_table[i];
						keep++;
					end
				end
				table_count = keep;
			end
		endcase
		r.motor_out_0 = drive[0];
		r.motor_out_1 = drive[1];
		r.motor_out_2 = drive[2];
		r.motor_out_3 = drive[3];
		r.motor_out_4 = drive[4];
		r.motor_out_5 = drive[5];
		r.motor_out_6 = drive[6];
		r.motor_out_7 = drive[7];
		r.entries_in_use = table_count[5:0];
		return r;
	endfunction

	// Stimulus table for the directed part. A row with a typed-in result
	// beat is checked against that value as well as against the predictor.
	typedef struct {
		in_beat_t beat;
		logic has_fixed;
		out_beat_t fixed;
	} directed_row_t;

	directed_row_t directed_rows[$];
	out_beat_t fixed_results[$];
	logic fixed_flags[$];

	// The sender: bursts of random length, random gaps in between. Valid
	// goes low only between beats, and the payload stays put while stalled.
	task automatic send_beat(input in_beat_t b);
		in_beat <= b;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	int burst_left;

	// When no gap is drawn, valid stays high so that valid is driven only once
	// per edge.
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(0, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap)
					@(posedge clk);
			end
			burst_left = $urandom_range(0, 8);
		end
	endtask

	// The prediction is made when the beat is accepted, watched at the edge
	// so that the order follows the block exactly.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			owed_results.push_back(predict_motor_drive(in_beat));
			accepted_count++;
		end
	end

	// Receiver stall pattern: alternating calm stretches and choppy ones.
	int stall_phase;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_phase <= 0;
		end else begin
			stall_phase <= stall_phase + 1;
			if (stall_phase[8])
				out_stall <= 1'b0;
			else
				out_stall <= ($urandom_range(0, 99) < 45);
		end
	end

	// Compares each result beat, field by field, with the oldest owed one.
	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			error_count++;
			$display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (owed_results.size() == 0) begin
				error_count++;
				$display("%0t result beat with nothing owed: expected none, actual %h",
					$time, out_beat);
			end else begin
				want = owed_results.pop_front();
				if (fixed_flags.size() > 0) begin
					if (fixed_flags.pop_front() && fixed_results[0] !== want) begin
						error_count++;
						$display("%0t typed-in row disagrees: expected %h, predicted %h",
							$time, fixed_results[0], want);
					end
					void'(fixed_results.pop_front());
				end
				check_field("motor_out_0", want.motor_out_0, out_beat.motor_out_0);
				check_field("motor_out_1", want.motor_out_1, out_beat.motor_out_1);
				check_field("motor_out_2", want.motor_out_2, out_beat.motor_out_2);
				check_field("motor_out_3", want.motor_out_3, out_beat.motor_out_3);
				check_field("motor_out_4", want.motor_out_4, out_beat.motor_out_4);
				check_field("motor_out_5", want.motor_out_5, out_beat.motor_out_5);
				check_field("motor_out_6", want.motor_out_6, out_beat.motor_out_6);
				check_field("motor_out_7", want.motor_out_7, out_beat.motor_out_7);
				check_field("status", want.status, out_beat.status);
				check_field("entries_in_use", want.entries_in_use, out_beat.entries_in_use);
			end
		end
	end

	// Register write while idle; the predictor copy follows along. After each
	// write cfg_valid is dropped for an edge so that back-to-back writes never
	// drive cfg_valid twice at the same edge.
	task automatic write_register(input logic idx, input logic [15:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_DEAD_BAND)
			band_q15 = 32'(value[14:0]);
		else
			expo_q15 = (value > OneQ15) ? OneQ15 : 32'(value);
		@(posedge clk);
	endtask

	// Waits until every owed beat arrived, then lets the block settle. The
	// first edge lets the monitor record a beat accepted at the current one.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (20)
			@(posedge clk);
	endtask

	function automatic in_beat_t random_axes(input in_beat_t b);
		// Mostly edge values (both extremes and +/- the band), with full-range values mixed in.
		logic [15:0] picks[6];
		for (int a = 0; a < 6; a++) begin
			case ($urandom_range(0, 5))
				0: picks[a] = 16'h8000;
				1: picks[a] = 16'h7FFF;
				2: picks[a] = 16'(band_q15);
				3: picks[a] = -16'(band_q15);
				default: picks[a] = 16'($urandom);
			endcase
		end
		b.axes_01 = {picks[1], picks[0]};
		b.axes_23 = {picks[3], picks[2]};
		b.axes_45 = {picks[5], picks[4]};
		return b;
	endfunction

	// Random beat: half are mix frames, the rest table traffic that keeps the table busy.
	function automatic in_beat_t random_beat();
		in_beat_t b;
		int pick;
		b = '0;
		b.axes_01 = $urandom;
		b.axes_23 = $urandom;
		b.axes_45 = $urandom;
		b.map_motor = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 7));
		b.map_kind = ($urandom_range(0, 7) == 0) ? 2'($urandom) : 2'($urandom_range(0, 1));
		b.map_axis = ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'($urandom_range(0, 5));
		b.map_scale = 16'($urandom);
		b.map_inverted = 1'($urandom);
		b.map_enabled = ($urandom_range(0, 5) != 0);
		b.entry_index = 5'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 50)
			b.func = FUNC_MIX;
		else if (pick < 80)
			b.func = FUNC_ADD;
		else if (pick < 93)
			b.func = FUNC_REMOVE;
		else
			b.func = FUNC_CLEAR;
		if (b.func == FUNC_MIX)
			b = random_axes(b);
		return b;
	endfunction

	function automatic void add_row(input in_beat_t b, input logic has_fixed,
		input out_beat_t fixed);
		directed_row_t row;
		row.beat = b;
		row.has_fixed = has_fixed;
		row.fixed = fixed;
		directed_rows.push_back(row);
	endfunction

	// Result of a mix frame with no contribution anywhere: every motor at
	// one half.
	function automatic out_beat_t idle_mix(input logic [5:0] count);
		out_beat_t r;
		r = '0;
		r.motor_out_0 = 16'd16384;
		r.motor_out_1 = 16'd16384;
		r.motor_out_2 = 16'd16384;
		r.motor_out_3 = 16'd16384;
		r.motor_out_4 = 16'd16384;
		r.motor_out_5 = 16'd16384;
		r.motor_out_6 = 16'd16384;
		r.motor_out_7 = 16'd16384;
		r.entries_in_use = count;
		return r;
	endfunction

	function automatic out_beat_t table_result(input logic st, input logic [5:0] count);
		out_beat_t r;
		r = '0;
		r.status = st;
		r.entries_in_use = count;
		return r;
	endfunction

	function automatic in_beat_t add_op(input logic [3:0] motor, input logic [1:0] kind,
		input logic [2:0] axis, input logic [15:0] scale, input logic inv, input logic en);
		in_beat_t b;
		b = '0;
		b.func = FUNC_ADD;
		b.map_motor = motor;
		b.map_kind = kind;
		b.map_axis = axis;
		b.map_scale = scale;
		b.map_inverted = inv;
		b.map_enabled = en;
		return b;
	endfunction

	function automatic in_beat_t mix_op(input logic [31:0] a01, input logic [31:0] a23,
		input logic [31:0] a45);
		in_beat_t b;
		b = '0;
		b.func = FUNC_MIX;
		b.axes_01 = a01;
		b.axes_23 = a23;
		b.axes_45 = a45;
		return b;
	endfunction

	function automatic void build_directed_table();
		in_beat_t b;
		// Empty table: every motor rests at one half, removal is rejected.
		add_row(mix_op(32'h7FFF_8000, 32'h8000_7FFF, 32'hFFFF_0001), 1'b1, idle_mix(6'd0));
		b = '0;
		b.func = FUNC_REMOVE;
		add_row(b, 1'b1, table_result(1'b1, 6'd0));
		// Entries covering each kind, axis range, motor range and flag.
		add_row(add_op(4'd0, 2'd0, 3'd0, 16'h7FFF, 1'b0, 1'b1), 1'b1, table_result(1'b0, 6'd1));
		add_row(add_op(4'd1, 2'd1, 3'd5, 16'h8000, 1'b1, 1'b1), 1'b1, table_result(1'b0, 6'd2));
		add_row(add_op(4'd2, 2'd2, 3'd1, 16'h1000, 1'b0, 1'b1), 1'b1, table_result(1'b0, 6'd3));
		add_row(add_op(4'd3, 2'd3, 3'd7, 16'h1000, 1'b1, 1'b1), 1'b1, table_result(1'b0, 6'd4));
		add_row(add_op(4'd15, 2'd0, 3'd2, 16'h1000, 1'b0, 1'b1), 1'b1, table_result(1'b0, 6'd5));
		add_row(add_op(4'd7, 2'd0, 3'd6, 16'h1000, 1'b0, 1'b1), 1'b1, table_result(1'b0, 6'd6));
		add_row(add_op(4'd4, 2'd0, 3'd3, 16'h1000, 1'b1, 1'b0), 1'b1, table_result(1'b0, 6'd7));
		add_row(add_op(4'd5, 2'd1, 3'd4, 16'hF000, 1'b0, 1'b1), 1'b1, table_result(1'b0, 6'd8));
		// Axis values at the extremes and exactly at +/- the deadzone.
		add_row(mix_op(32'h8000_7FFF, 32'h8000_7FFF, 32'h8000_7FFF), 1'b0, '0);
		add_row(mix_op(32'h0CCD_0CCD, 32'hF333_0CCD, 32'hF333_0CCD), 1'b0, '0);
		add_row(mix_op(32'h0CCE_F332, 32'h0000_0000, 32'h7FFF_8000), 1'b0, '0);
		// Remove at the last valid index, out of range, the top index, then index 0.
		b = '0;
		b.func = FUNC_REMOVE;
		b.entry_index = 5'd7;
		add_row(b, 1'b1, table_result(1'b0, 6'd7));
		b.entry_index = 5'd7;
		add_row(b, 1'b1, table_result(1'b1, 6'd7));
		b.entry_index = 5'd31;
		add_row(b, 1'b1, table_result(1'b1, 6'd7));
		b.entry_index = 5'd0;
		add_row(b, 1'b1, table_result(1'b0, 6'd6));
		// Clear of a motor with entries, then of one with none.
		b = '0;
		b.func = FUNC_CLEAR;
		b.map_motor = 4'd15;
		add_row(b, 1'b1, table_result(1'b0, 6'd5));
		b.map_motor = 4'd9;
		add_row(b, 1'b1, table_result(1'b0, 6'd5));
		add_row(mix_op(32'h4000_C000, 32'h2000_E000, 32'h1234_EDCB), 1'b0, '0);
	endfunction

	// Fill the table until an add is rejected, mix on a full table, then
	// empty it through a removal and clears of every motor.
	task automatic fill_and_empty();
		in_beat_t b;
		while (table_count < TableEntriesDef) begin
			b = random_beat();
			b.func = FUNC_ADD;
			send_beat(b);
			pace_sender();
		end
		b = random_beat();
		b.func = FUNC_ADD;
		send_beat(b);
		b = random_beat();
		b.func = FUNC_MIX;
		send_beat(b);
		b.func = FUNC_REMOVE;
		b.entry_index = 5'd31;
		send_beat(b);
		for (int m = 0; m < 16; m++) begin
			b.func = FUNC_CLEAR;
			b.map_motor = 4'(m);
			send_beat(b);
			pace_sender();
		end
		drain();
	endtask

	initial begin
		in_beat_t b;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_beat = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_DEAD_BAND;
		cfg_data = '0;
		error_count = 0;
		accepted_count = 0;
		burst_left = 0;
		table_count = 0;
		band_q15 = 3277;
		expo_q15 = 0;
		for (int i = 0; i < TableEntriesDef; i++)
			mix_table[i] = '0;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset settings.
		build_directed_table();
		foreach (directed_rows[i]) begin
			fixed_flags.push_back(directed_rows[i].has_fixed);
			fixed_results.push_back(directed_rows[i].fixed);
			send_beat(directed_rows[i].beat);
			pace_sender();
		end
		drain();

		// Random phases, each under its own register setting. The first
		// phases pin the extremes of both registers; expo_mix values above
		// one are clamped by the block.
		for (int phase = 0; phase < 10; phase++) begin
			case (phase)
				0: begin
					write_register(CFG_DEAD_BAND, 16'd0);
					write_register(CFG_EXPO_MIX, 16'd0);
				end
				1: begin
					write_register(CFG_DEAD_BAND, 16'h7FFF);
					write_register(CFG_EXPO_MIX, 16'd32768);
				end
				2: begin
					write_register(CFG_DEAD_BAND, 16'hFFFF);
					write_register(CFG_EXPO_MIX, 16'hFFFF);
				end
				default: begin
					write_register(CFG_DEAD_BAND, 16'($urandom_range(0, 16384)));
					write_register(CFG_EXPO_MIX, 16'($urandom_range(0, 40000)));
				end
			endcase
			if (phase == 4)
				fill_and_empty();
			for (int n = 0; n < 55; n++) begin
				b = random_beat();
				send_beat(b);
				pace_sender();
			end
			drain();
		end

		if (error_count == 0 && owed_results.size() == 0) begin
			$display("axis_to_motor_mixer_core verification clean");
		end else begin
			$display("axis_to_motor_mixer_core verification failed");
		end
		$finish;
	end

	// Watchdog: a mix frame shapes each enabled entry in turn, so with the
	// table full the limit is generous.
	initial begin
		#50_000_000;
		$display("axis_to_motor_mixer_core verification failed");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+src
src/amm_pkg.sv
src/amm_ram.sv
src/amm_datapath.sv
src/amm_ctrl.sv
src/axis_to_motor_mixer_core.sv
tb/tb_axis_to_motor_mixer_core.sv
